// ===== rtl/fts_relevance_rank_score_top_macros.svh =====
// Assertion macros shared by the relevance scorer RTL.
// Uses the clock and reset names of the including module; no other dependencies.
`ifndef FTS_RELEVANCE_RANK_SCORE_TOP_MACROS_SVH
`define FTS_RELEVANCE_RANK_SCORE_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define FTS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define FTS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/fts_rrs_pkg.sv =====
// Package for the relevance scorer: field widths, status and register codes,
// and the job record passed from the front end to the back end. No dependencies.
`timescale 1ns / 1ps

package fts_rrs_pkg;

   localparam int WORD_W      = 32;
   localparam int WEIGHT_W    = 16;
   localparam int RATIO_W     = 32;
   localparam int SCORE_W     = 48;
   localparam int STATUS_W    = 3;
   localparam int CCOUNT_W    = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int DEF_MAX_COLUMNS = 6;
   localparam int DEF_MAX_PHRASES = 64;
   localparam int QUEUE_DEPTH     = 4;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TRUNC    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_PHRASES  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SAT      = 3'd4;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_BASE  = 3'd1;

   localparam logic [CCOUNT_W-1:0]        COLUMN_COUNT_RESET = 3'd1;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_RESET       = 16'sd256;

   // One unit of work for the back end: a term to add, the end of a record, or both.
   typedef struct packed {
      logic                       is_term;
      logic                       is_end;
      logic [WORD_W-1:0]          hit;
      logic [WORD_W-1:0]          glob_count;
      logic signed [WEIGHT_W-1:0] weight;
      logic [STATUS_W-1:0]        end_status;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_flags_type;

endpackage

// ===== rtl/fts_rrs_if.sv =====
// Channel interfaces of the relevance scorer: record words in, results out,
// and register writes. Depends on fts_rrs_pkg.
`timescale 1ns / 1ps

interface fts_rrs_req_if import fts_rrs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] matchinfo_word;
   logic              last;

   modport source (output valid, output matchinfo_word, output last, input ready);
   modport sink   (input valid, input matchinfo_word, input last, output ready);
endinterface

interface fts_rrs_rsp_if import fts_rrs_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [SCORE_W-1:0] score;
   logic [STATUS_W-1:0]       status;

   modport source (output valid, output score, output status, input ready);
   modport sink   (input valid, input score, input status, output ready);
endinterface

interface fts_rrs_csr_if import fts_rrs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/fts_relevance_rank_score_top.sv =====
// Relevance scorer top level: column registers, front end, job queue, back end.
// Depends on fts_rrs_pkg, fts_rrs_if, fts_rrs_front, fts_rrs_queue and fts_rrs_back.
//
// The block takes one matchinfo record as a stream of 32-bit words and returns
// one score and status per record; the word marked last ends the record. Apart
// from that word, header words, ignored words and the words of triples with a
// zero hit count push no job to the back end. A triple with a nonzero hit count
// passes through the back end in steps: issue, the radix-2 divider (skipped when
// the ratio saturates), one multiply and one accumulate. A four-entry job queue
// lets the front end run ahead, taking words while the back end is busy until
// the queue is full. The result is registered once the output register is free
// and waits there while the next record flows in.
// Register writes are taken every cycle and must be made while the block is idle.
`timescale 1ns / 1ps

module fts_relevance_rank_score_top import fts_rrs_pkg::*; #(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_PHRASES = DEF_MAX_PHRASES
) (
   input  logic          clock,
   input  logic          reset,
   fts_rrs_req_if.sink   req_chan,
   fts_rrs_rsp_if.source rsp_chan,
   fts_rrs_csr_if.sink   csr_chan
);

   logic [CCOUNT_W-1:0]        column_count_ff;
   logic signed [WEIGHT_W-1:0] weight_ff [MAX_COLUMNS];
   logic                       csr_write;

   logic                       push;
   job_type                    push_job;
   job_type                    head;
   queue_flags_type            q_flags;
   logic                       pop;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   // Weights for columns beyond MAX_COLUMNS are never read, so writes to them are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= COLUMN_COUNT_RESET;
         for (int i = 0; i < MAX_COLUMNS; i++) begin
            weight_ff[i] <= WEIGHT_RESET;
         end
      end else if (csr_write) begin
         if (csr_chan.index == CSR_COLUMN_COUNT) begin
            column_count_ff <= csr_chan.data[CCOUNT_W-1:0];
         end
         for (int i = 0; i < MAX_COLUMNS; i++) begin
            if (csr_chan.index == CSR_INDEX_W'(int'(CSR_WEIGHT_BASE) + i)) begin
               weight_ff[i] <= csr_chan.data[WEIGHT_W-1:0];
            end
         end
      end
   end

   fts_rrs_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_PHRASES (MAX_PHRASES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .column_count (column_count_ff),
      .weights      (weight_ff),
      .q_flags      (q_flags),
      .push         (push),
      .push_job     (push_job)
   );

   fts_rrs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .flags    (q_flags)
   );

   fts_rrs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_flags  (q_flags),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== rtl/fts_rrs_front.sv =====
// Front end: parses the record word stream and turns nonzero hit triples and the
// record end into jobs for the back end. Depends on fts_rrs_pkg and fts_rrs_if.
`timescale 1ns / 1ps

module fts_rrs_front import fts_rrs_pkg::*; #(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_PHRASES = DEF_MAX_PHRASES
) (
   input  logic                       clock,
   input  logic                       reset,
   fts_rrs_req_if.sink                req_chan,
   input  logic [CCOUNT_W-1:0]        column_count,
   input  logic signed [WEIGHT_W-1:0] weights [MAX_COLUMNS],
   input  queue_flags_type            q_flags,
   output logic                       push,
   output job_type                    push_job
);

   localparam int PHRASE_W = $clog2(MAX_PHRASES + 1);
   localparam int COL_W    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

   localparam logic [2:0] SLOT_PHRASES = 3'd0;
   localparam logic [2:0] SLOT_COLUMNS = 3'd1;
   localparam logic [2:0] SLOT_HIT     = 3'd2;
   localparam logic [2:0] SLOT_GLOBAL  = 3'd3;
   localparam logic [2:0] SLOT_SKIP    = 3'd4;
   localparam logic [2:0] SLOT_DONE    = 3'd5;

   logic [2:0]          slot_ff, slot_in;
   logic [PHRASE_W-1:0] ptotal_ff, ptotal_in;
   logic [PHRASE_W-1:0] pidx_ff, pidx_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [WORD_W-1:0]   held_ff, held_in;
   logic [STATUS_W-1:0] fault_ff, fault_in;

   logic                accept;
   logic                term;
   logic [STATUS_W-1:0] end_status;
   logic [WORD_W-1:0]   word;

   // A transaction may push a job, so words are taken only while the queue has room.
   assign req_chan.ready = !q_flags.full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign word           = req_chan.matchinfo_word;

   always_comb begin
      slot_in   = slot_ff;
      ptotal_in = ptotal_ff;
      pidx_in   = pidx_ff;
      col_in    = col_ff;
      held_in   = held_ff;
      fault_in  = fault_ff;
      term      = 1'b0;

      unique case (slot_ff)
         SLOT_PHRASES: begin
            if (word > WORD_W'(MAX_PHRASES)) begin
               fault_in = ST_PHRASES;
               slot_in  = SLOT_DONE;
            end else begin
               ptotal_in = word[PHRASE_W-1:0];
               slot_in   = SLOT_COLUMNS;
            end
         end
         SLOT_COLUMNS: begin
            if (column_count == '0 || column_count > CCOUNT_W'(MAX_COLUMNS) ||
                word != WORD_W'(column_count)) begin
               fault_in = ST_MISMATCH;
               slot_in  = SLOT_DONE;
            end else begin
               slot_in = (ptotal_ff == '0) ? SLOT_DONE : SLOT_HIT;
            end
         end
         SLOT_HIT: begin
            held_in = word;
            slot_in = SLOT_GLOBAL;
         end
         SLOT_GLOBAL: begin
            term    = (held_ff != '0);
            slot_in = SLOT_SKIP;
         end
         SLOT_SKIP: begin
            slot_in = SLOT_HIT;
            if ((int'(col_ff) + 1) >= int'(column_count)) begin
               col_in  = '0;
               pidx_in = PHRASE_W'(pidx_ff + 1'b1);
               if ((int'(pidx_ff) + 1) >= int'(ptotal_ff)) begin
                  slot_in = SLOT_DONE;
               end
            end else begin
               col_in = COL_W'(col_ff + 1'b1);
            end
         end
         SLOT_DONE: begin
         end
         default: begin
         end
      endcase

      if (fault_in == ST_PHRASES || fault_in == ST_MISMATCH) begin
         end_status = fault_in;
      end else if (slot_in != SLOT_DONE) begin
         end_status = ST_TRUNC;
      end else begin
         end_status = ST_OK;
      end

      // The record is cleared as soon as its last word has been taken.
      if (req_chan.last) begin
         slot_in   = SLOT_PHRASES;
         ptotal_in = '0;
         pidx_in   = '0;
         col_in    = '0;
         held_in   = '0;
         fault_in  = ST_OK;
      end
   end

   assign push                = accept && (term || req_chan.last);
   assign push_job.is_term    = term;
   assign push_job.is_end     = req_chan.last;
   assign push_job.hit        = held_ff;
   assign push_job.glob_count = word;
   assign push_job.weight     = weights[col_ff];
   assign push_job.end_status = end_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff   <= SLOT_PHRASES;
         ptotal_ff <= '0;
         pidx_ff   <= '0;
         col_ff    <= '0;
         held_ff   <= '0;
         fault_ff  <= ST_OK;
      end else if (accept) begin
         slot_ff   <= slot_in;
         ptotal_ff <= ptotal_in;
         pidx_ff   <= pidx_in;
         col_ff    <= col_in;
         held_ff   <= held_in;
         fault_ff  <= fault_in;
      end
   end

endmodule

// ===== rtl/fts_rrs_queue.sv =====
// Short job queue between the front end and the back end, built from registers.
// Depends on fts_rrs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "fts_relevance_rank_score_top_macros.svh"

module fts_rrs_queue import fts_rrs_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  job_type         push_job,
   input  logic            pop,
   output job_type         head,
   output queue_flags_type flags
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign flags.empty = (count_ff == '0);
   assign flags.full  = (count_ff == CNT_W'(DEPTH));
   assign do_push     = push && !flags.full;
   assign do_pop      = pop && !flags.empty;
   assign head        = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
         end
         if (do_push && !do_pop) begin
            count_ff <= CNT_W'(count_ff + 1'b1);
         end else if (do_pop && !do_push) begin
            count_ff <= CNT_W'(count_ff - 1'b1);
         end
      end
   end

   `FTS_ASSERT_IMPL(a_count_range, 1'b1, count_ff <= CNT_W'(DEPTH), "queue count over depth")
   `FTS_ASSERT_IMPL(a_pop_nonempty, pop, !flags.empty, "pop from an empty queue")
   `FTS_ASSERT_NEXT(a_push_pop_hold, do_push && do_pop, $stable(count_ff), "count moved on push and pop")

endmodule

// ===== rtl/fts_rrs_back.sv =====
// Back end: divides hit by global count, weights the ratio, adds it to the
// saturating score and delivers the result. Depends on fts_rrs_pkg, fts_rrs_if, macros.
`timescale 1ns / 1ps
`include "fts_relevance_rank_score_top_macros.svh"

module fts_rrs_back import fts_rrs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  job_type         head,
   input  queue_flags_type q_flags,
   output logic            pop,
   fts_rrs_rsp_if.source   rsp_chan
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_ACC  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   localparam int STEP_W = $clog2(RATIO_W);
   localparam int HALF_W = WORD_W / 2;

   localparam logic signed [SCORE_W-1:0] SUM_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam logic signed [SCORE_W-1:0] SUM_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

   logic [2:0]                 state_ff, state_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [WORD_W-1:0]          div_ff, div_in;
   logic [WORD_W-1:0]          rem_ff, rem_in;
   logic [RATIO_W-1:0]         quo_ff, quo_in;
   logic signed [WEIGHT_W-1:0] weight_ff, weight_in;
   logic                       is_end_ff, is_end_in;
   logic [STATUS_W-1:0]        end_status_ff, end_status_in;
   logic signed [SCORE_W-1:0]  term_ff, term_in;
   logic signed [SCORE_W-1:0]  sum_ff, sum_in;
   logic                       sat_ff, sat_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SCORE_W-1:0]  rsp_score_ff, rsp_score_in;
   logic [STATUS_W-1:0]        rsp_status_ff, rsp_status_in;

   logic [WORD_W:0]            trial;
   logic [WORD_W:0]            trial_diff;
   logic signed [SCORE_W:0]    product;
   logic signed [SCORE_W:0]    wide_sum;
   logic                       out_free;

   // One restoring step: shift in the next dividend bit and subtract when it fits.
   assign trial      = {rem_ff, quo_ff[RATIO_W-1]};
   assign trial_diff = trial - {1'b0, div_ff};
   assign product    = $signed({1'b0, quo_ff}) * weight_ff;
   assign wide_sum   = {sum_ff[SCORE_W-1], sum_ff} + {term_ff[SCORE_W-1], term_ff};
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;

   assign pop = (state_ff == S_IDLE) && !q_flags.empty;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      weight_in     = weight_ff;
      is_end_in     = is_end_ff;
      end_status_in = end_status_ff;
      term_in       = term_ff;
      sum_in        = sum_ff;
      sat_in        = sat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_score_in  = rsp_score_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (!q_flags.empty) begin
               weight_in     = head.weight;
               is_end_in     = head.is_end;
               end_status_in = head.end_status;
               if (head.is_term) begin
                  // The quotient overflows 32 bits exactly when hit / 2^16 >= global,
                  // which also covers a zero global count.
                  if (WORD_W'(head.hit[WORD_W-1:HALF_W]) >= head.glob_count) begin
                     quo_in   = '1;
                     state_in = S_MUL;
                  end else begin
                     div_in   = head.glob_count;
                     rem_in   = WORD_W'(head.hit[WORD_W-1:HALF_W]);
                     quo_in   = {head.hit[HALF_W-1:0], {HALF_W{1'b0}}};
                     step_in  = '1;
                     state_in = S_DIV;
                  end
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_DIV: begin
            if (!trial_diff[WORD_W]) begin
               rem_in = trial_diff[WORD_W-1:0];
               quo_in = {quo_ff[RATIO_W-2:0], 1'b1};
            end else begin
               rem_in = trial[WORD_W-1:0];
               quo_in = {quo_ff[RATIO_W-2:0], 1'b0};
            end
            step_in = STEP_W'(step_ff - 1'b1);
            if (step_ff == '0) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // The magnitude of ratio times weight stays below 2^47.
            term_in  = product[SCORE_W-1:0];
            state_in = S_ACC;
         end
         S_ACC: begin
            if (wide_sum[SCORE_W] != wide_sum[SCORE_W-1]) begin
               sum_in = wide_sum[SCORE_W] ? SUM_MIN : SUM_MAX;
               sat_in = 1'b1;
            end else begin
               sum_in = wide_sum[SCORE_W-1:0];
            end
            state_in = is_end_ff ? S_OUT : S_IDLE;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (end_status_ff == ST_OK) begin
                  rsp_status_in = sat_ff ? ST_SAT : ST_OK;
                  rsp_score_in  = sum_ff;
               end else begin
                  rsp_status_in = end_status_ff;
                  rsp_score_in  = '0;
               end
               sum_in   = '0;
               sat_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      weight_ff     <= weight_in;
      is_end_ff     <= is_end_in;
      end_status_ff <= end_status_in;
      term_ff       <= term_in;
      rsp_score_ff  <= rsp_score_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.score  = rsp_score_ff;
   assign rsp_chan.status = rsp_status_ff;

   `FTS_ASSERT_IMPL(a_div_nonzero, state_ff == S_DIV, div_ff != '0, "divide with zero divisor")
   `FTS_ASSERT_IMPL(a_rsp_from_out, $rose(rsp_valid_ff), $past(state_ff) == S_OUT, "result outside output step")
   `FTS_ASSERT_IMPL(a_err_score_zero, rsp_valid_ff && rsp_status_ff != ST_OK && rsp_status_ff != ST_SAT, rsp_score_ff == '0, "error result carries a score")

endmodule

// ===== dv/fts_relevance_rank_score_checker.sv =====
// Checker for the relevance scorer: tracks register writes, predicts one score
// and status per record from the accepted words, and compares every result.
// Depends on fts_rrs_pkg and fts_rrs_if.
`timescale 1ns / 1ps

module fts_relevance_rank_score_checker import fts_rrs_pkg::*; #(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_PHRASES = DEF_MAX_PHRASES
) (
   input  logic   clock,
   input  logic   reset,
   fts_rrs_req_if req_mon,
   fts_rrs_rsp_if rsp_mon,
   fts_rrs_csr_if csr_mon,
   output int     fail_count,
   output int     pending_count
);

   localparam longint SCORE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SCORE_MIN = -SCORE_MAX - 1;

   typedef enum logic [2:0] {
      AT_PHRASE_COUNT,
      AT_COLUMN_COUNT,
      AT_HIT,
      AT_GLOBAL,
      AT_IGNORED,
      AT_END
   } word_slot_type;

   typedef struct packed {
      logic [SCORE_W-1:0]  score;
      logic [STATUS_W-1:0] status;
   } score_result_type;

   // Register copies.
   logic [CCOUNT_W-1:0]        column_count;
   logic signed [WEIGHT_W-1:0] col_weight [DEF_MAX_COLUMNS];

   // Record progress.
   word_slot_type       word_slot;
   int                  phrases_in_record;
   int                  phrase_no;
   int                  column_no;
   logic [WORD_W-1:0]   pending_hit;
   longint              running_score;
   logic [STATUS_W-1:0] record_fault;
   bit                  clamped;

   score_result_type expected_scores[$];
   score_result_type oldest;
   int               weight_slot;
   int               failures = 0;

   assign fail_count = failures;

   function automatic longint hit_ratio_q16(input logic [WORD_W-1:0] hit,
                                            input logic [WORD_W-1:0] glob);
      logic [47:0] quotient;
      if (glob == '0) return 64'h0000_0000_FFFF_FFFF;
      quotient = {hit, 16'h0000} / glob;
      return (quotient > 48'h0000_FFFF_FFFF) ? 64'h0000_0000_FFFF_FFFF : longint'(quotient);
   endfunction

   task automatic add_clamped(input longint term);
      longint sum;
      sum = running_score + term;
      if (sum > SCORE_MAX) begin
         sum = SCORE_MAX;
         clamped = 1'b1;
      end
      if (sum < SCORE_MIN) begin
         sum = SCORE_MIN;
         clamped = 1'b1;
      end
      running_score = sum;
   endtask

   task automatic clear_record();
      word_slot = AT_PHRASE_COUNT;
      phrases_in_record = 0;
      phrase_no = 0;
      column_no = 0;
      pending_hit = '0;
      running_score = 0;
      record_fault = ST_OK;
      clamped = 1'b0;
   endtask

   task automatic take_word(input logic [WORD_W-1:0] word, input logic is_last);
      score_result_type outcome;
      case (word_slot)
         AT_PHRASE_COUNT: begin
            if (word > MAX_PHRASES) begin
               record_fault = ST_PHRASES;
               word_slot = AT_END;
            end else begin
               phrases_in_record = int'(word);
               word_slot = AT_COLUMN_COUNT;
            end
         end
         AT_COLUMN_COUNT: begin
            if (column_count == '0 || column_count > MAX_COLUMNS ||
                word != WORD_W'(column_count)) begin
               record_fault = ST_MISMATCH;
               word_slot = AT_END;
            end else begin
               word_slot = (phrases_in_record == 0) ? AT_END : AT_HIT;
            end
         end
         AT_HIT: begin
            pending_hit = word;
            word_slot = AT_GLOBAL;
         end
         AT_GLOBAL: begin
            if (pending_hit != '0)
               add_clamped(hit_ratio_q16(pending_hit, word) * longint'(col_weight[column_no]));
            word_slot = AT_IGNORED;
         end
         AT_IGNORED: begin
            column_no++;
            word_slot = AT_HIT;
            if (column_no >= column_count) begin
               column_no = 0;
               phrase_no++;
               if (phrase_no >= phrases_in_record) word_slot = AT_END;
            end
         end
         default: ;
      endcase

      if (!is_last) return;

      // A header fault outranks truncation, which outranks saturation.
      if (record_fault != ST_OK) outcome.status = record_fault;
      else if (word_slot != AT_END) outcome.status = ST_TRUNC;
      else if (clamped) outcome.status = ST_SAT;
      else outcome.status = ST_OK;
      outcome.score = (outcome.status == ST_OK || outcome.status == ST_SAT) ?
                      running_score[SCORE_W-1:0] : '0;
      expected_scores.push_back(outcome);
      clear_record();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         column_count = COLUMN_COUNT_RESET;
         foreach (col_weight[i]) col_weight[i] = WEIGHT_RESET;
         clear_record();
         expected_scores.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == CSR_COLUMN_COUNT) begin
               column_count = csr_mon.data[CCOUNT_W-1:0];
            end else begin
               weight_slot = int'(csr_mon.index) - int'(CSR_WEIGHT_BASE);
               if (weight_slot >= 0 && weight_slot < DEF_MAX_COLUMNS)
                  col_weight[weight_slot] = csr_mon.data;
            end
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_scores.size() == 0) begin
               $display("%0t: result with none expected, actual score %0d status %0d",
                        $time, rsp_mon.score, rsp_mon.status);
               failures++;
            end else begin
               oldest = expected_scores.pop_front();
               if (rsp_mon.score !== $signed(oldest.score)) begin
                  $display("%0t: score mismatch, expected %0d, actual %0d",
                           $time, $signed(oldest.score), rsp_mon.score);
                  failures++;
               end
               if (rsp_mon.status !== oldest.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, oldest.status, rsp_mon.status);
                  failures++;
               end
            end
         end

         if (req_mon.valid && req_mon.ready)
            take_word(req_mon.matchinfo_word, req_mon.last);
      end
      pending_count = expected_scores.size();
   end

endmodule

// ===== dv/fts_relevance_rank_score_top_test.sv =====
// Testbench top for the relevance scorer: clock, reset, register setup and
// record stimulus, with the checker beside the block giving the verdict.
// Depends on fts_rrs_pkg, fts_rrs_if, fts_relevance_rank_score_top and the checker.
`timescale 1ns / 1ps

module fts_relevance_rank_score_top_test import fts_rrs_pkg::*;;

   localparam int WATCHDOG_LIMIT    = 5000;
   localparam int DRAIN_CYCLES      = 200;
   localparam int WORDS_PER_SEGMENT = 180;
   localparam int SEGMENT_COUNT     = 9;

   typedef enum {W_MAX, W_MIN, W_ALTERNATE, W_RANDOM} weight_style_type;

   logic clock;
   logic reset;

   fts_rrs_req_if req_chan ();
   fts_rrs_rsp_if rsp_chan ();
   fts_rrs_csr_if csr_chan ();

   int fail_count;
   int pending_count;
   int send_idle_pct = 12;
   int recv_stall_pct = 87;
   int words_sent = 0;
   int seg_start;
   int stuck_cycles = 0;

   logic [CCOUNT_W-1:0] cfg_columns;
   logic [WORD_W-1:0]   rec_words[$];

   fts_relevance_rank_score_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   fts_relevance_rank_score_checker score_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_mon       (csr_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock) rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);

   // Ends the run when no transaction has moved on any channel for too long.
   initial begin
      while (stuck_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready) || (csr_chan.valid && csr_chan.ready))
            stuck_cycles = 0;
         else
            stuck_cycles++;
      end
      $display("fts_relevance_rank_score_top_test: FAIL");
      $finish;
   end

   // Leaves valid high on return, so back-to-back words need no gap.
   task automatic send_word(input logic [WORD_W-1:0] word, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.matchinfo_word <= word;
      req_chan.last <= is_last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic send_record();
      foreach (rec_words[i]) send_word(rec_words[i], i == rec_words.size() - 1);
   endtask

   task automatic pause_for_results();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   // The back end may still be draining its job queue after the last result.
   task automatic quiesce();
      pause_for_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic configure(input logic [CCOUNT_W-1:0] cols, input weight_style_type style);
      logic [CSR_DATA_W-1:0] weight;
      quiesce();
      write_reg(CSR_COLUMN_COUNT, CSR_DATA_W'(cols));
      for (int i = 0; i < DEF_MAX_COLUMNS; i++) begin
         case (style)
            W_MAX:       weight = 16'h7FFF;
            W_MIN:       weight = 16'h8000;
            W_ALTERNATE: weight = (i % 2 == 0) ? 16'h7FFF : 16'h8000;
            default: begin
               case ($urandom_range(4))
                  0:       weight = 16'h0000;
                  1:       weight = 16'h0100;
                  2:       weight = 16'hFF00;
                  default: weight = CSR_DATA_W'($urandom);
               endcase
            end
         endcase
         write_reg(CSR_WEIGHT_BASE + CSR_INDEX_W'(i), weight);
      end
      csr_chan.valid <= 1'b0;
      cfg_columns = cols;
   endtask

   function automatic logic [WORD_W-1:0] pick_hit();
      case ($urandom_range(9))
         0, 1, 2:    return '0;
         3, 4, 5, 6: return WORD_W'($urandom_range(100, 1));
         7, 8:       return $urandom;
         default:    return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] pick_global(input logic [WORD_W-1:0] hit);
      case ($urandom_range(9))
         0:             return '0;
         1, 2, 3, 4, 5: return hit + WORD_W'($urandom_range(1000));
         6, 7:          return WORD_W'($urandom_range(100, 1));
         default:       return $urandom;
      endcase
   endfunction

   // Mostly complete records with random counts; the rest are cut short or
   // carry a bad header so that the fault paths stay busy.
   task automatic build_random_record();
      int                phrases;
      int                kind;
      int                keep;
      logic [WORD_W-1:0] hit;
      rec_words.delete();
      kind = $urandom_range(99);
      if ($urandom_range(199) == 0 && cfg_columns <= 1) phrases = MAX_PHRASE_LIMIT();
      else if ($urandom_range(9) == 0) phrases = $urandom_range(12, 4);
      else phrases = $urandom_range(3);
      rec_words.push_back(WORD_W'(phrases));
      rec_words.push_back(WORD_W'(cfg_columns));
      for (int p = 0; p < phrases; p++) begin
         for (int c = 0; c < cfg_columns; c++) begin
            hit = pick_hit();
            rec_words.push_back(hit);
            rec_words.push_back(pick_global(hit));
            rec_words.push_back($urandom);
         end
      end
      if (kind < 70) begin
         if ($urandom_range(6) == 0)
            repeat ($urandom_range(3, 1)) rec_words.push_back($urandom);
      end else if (kind < 82) begin
         keep = $urandom_range(rec_words.size() - 2) + 1;
         while (rec_words.size() > keep) void'(rec_words.pop_back());
      end else if (kind < 91) begin
         rec_words[1] = $urandom_range(1) ? $urandom :
                        {29'd0, cfg_columns + 3'($urandom_range(7, 1))};
         keep = 2 + $urandom_range(4);
         while (rec_words.size() > keep) void'(rec_words.pop_back());
      end else begin
         case ($urandom_range(2))
            0:       rec_words[0] = WORD_W'(DEF_MAX_PHRASES + 1);
            1:       rec_words[0] = WORD_W'($urandom_range(127, DEF_MAX_PHRASES + 1));
            default: rec_words[0] = $urandom | 32'h8000_0000;
         endcase
         keep = 1 + $urandom_range(3);
         while (rec_words.size() > keep) void'(rec_words.pop_back());
      end
   endtask

   function automatic int MAX_PHRASE_LIMIT();
      return DEF_MAX_PHRASES;
   endfunction

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.matchinfo_word = '0;
      req_chan.last = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;
      cfg_columns = COLUMN_COUNT_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed records under the reset register values.
      rec_words = '{32'd0, 32'd1};
      send_record();
      rec_words = '{32'd1, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd5, 32'd6};
      send_record();
      rec_words = '{32'hFFFF_FFFF, 32'd1};
      send_record();
      rec_words = '{32'd65, 32'd2};
      send_record();
      rec_words = '{32'd64, 32'd1, 32'd3};
      send_record();
      rec_words = '{32'd1, 32'd2};
      send_record();
      rec_words = '{32'd0};
      send_record();

      // Largest weight: a saturated ratio nearly fills the score, so the sum clamps.
      configure(3'd1, W_MAX);
      rec_words = '{32'd3, 32'd1, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0, 32'd0,
                    32'd7, 32'd3, 32'd0};
      send_record();

      for (int seg = 0; seg < SEGMENT_COUNT; seg++) begin
         case (seg)
            0:       configure(3'd6, W_MAX);
            1:       configure(3'd3, W_RANDOM);
            2:       configure(3'd0, W_RANDOM);
            3:       configure(3'd1, W_MIN);
            4:       configure(3'd5, W_RANDOM);
            5:       configure(3'd7, W_ALTERNATE);
            6:       configure(3'd2, W_RANDOM);
            7:       configure(3'd4, W_ALTERNATE);
            default: configure(3'd6, W_RANDOM);
         endcase
         send_idle_pct = (seg < 3) ? 12 : (seg < 6) ? 87 : 0;
         recv_stall_pct = (seg < 3) ? 87 : (seg < 6) ? 12 : 0;
         seg_start = words_sent;
         while (words_sent - seg_start < WORDS_PER_SEGMENT) begin
            build_random_record();
            send_record();
            if ($urandom_range(39) == 0) pause_for_results();
         end
      end

      quiesce();
      if (fail_count == 0)
         $display("fts_relevance_rank_score_top_test: PASS");
      else
         $display("fts_relevance_rank_score_top_test: FAIL");
      $finish;
   end

endmodule
